// ===== hdl/mlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mlt_pkg;

	// Bits per word on the line, transmitted and received
	localparam int WORD_BITS = 8;
	localparam int BYTE_BITS = 8;

	// Transmit bit counter runs 0..WORD_BITS; receive counter 0..WORD_BITS-1
	localparam int TX_CNT_W = $clog2(WORD_BITS + 1);
	localparam int RX_CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	// Hold register padded with zeros so every counter value selects a bit
	localparam int TX_PAD_W = BYTE_BITS + (2 ** TX_CNT_W);

	typedef struct packed {
		logic                 tx_line;
		logic                 tx_busy;
		logic                 rx_byte_valid;
		logic [BYTE_BITS-1:0] rx_byte;
	} mlt_result_t;

endpackage

`default_nettype wire

// ===== hdl/mlt_tx_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlt_tx_enc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          tx_load,
	input  wire logic [mlt_pkg::BYTE_BITS-1:0] tx_data,
	output logic                               tx_line,
	output logic                               tx_busy
);

	logic                         half_q;
	logic                         active_q;
	logic [mlt_pkg::TX_CNT_W-1:0] count_q;
	logic [mlt_pkg::BYTE_BITS-1:0] hold_q;
	logic                         bit_q;

	logic                          load_take;
	logic                          act;
	logic [mlt_pkg::TX_CNT_W-1:0]  cnt;
	logic [mlt_pkg::BYTE_BITS-1:0] hold;
	logic [mlt_pkg::TX_PAD_W-1:0]  hold_pad;
	logic                          bit_n;
	logic                          active_n;
	logic [mlt_pkg::TX_CNT_W-1:0]  count_n;

	always_comb begin
		load_take = tx_load & ~active_q;
		act       = active_q | load_take;
		cnt       = load_take ? '0 : count_q;
		hold      = load_take ? tx_data : hold_q;
		hold_pad  = {{(2 ** mlt_pkg::TX_CNT_W){1'b0}}, hold};
		if (!half_q) begin
			// first half: pick the next bit, or a coded zero while idle
			bit_n    = act ? hold_pad[cnt] : 1'b0;
			count_n  = act ? cnt + 1'b1 : cnt;
			active_n = act;
			tx_line  = bit_n;
		end else begin
			bit_n   = bit_q;
			tx_line = ~bit_q;
			if (cnt >= mlt_pkg::TX_CNT_W'(mlt_pkg::WORD_BITS)) begin
				active_n = 1'b0;
				count_n  = '0;
			end else begin
				active_n = act;
				count_n  = cnt;
			end
		end
		tx_busy = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 1'b0;
			active_q <= 1'b0;
			count_q  <= '0;
			hold_q   <= '0;
			bit_q    <= 1'b0;
		end else if (step) begin
			half_q   <= ~half_q;
			active_q <= active_n;
			count_q  <= count_n;
			hold_q   <= hold;
			bit_q    <= bit_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mlt_rx_dec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlt_rx_dec (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          rx_level,
	output logic                               rx_byte_valid,
	output logic [mlt_pkg::BYTE_BITS-1:0]      rx_byte
);

	logic                          half_q;
	logic                          late_q;
	logic [mlt_pkg::WORD_BITS-1:0] shift_q;
	logic [mlt_pkg::RX_CNT_W-1:0]  count_q;

	logic                                          have_bit;
	logic [mlt_pkg::WORD_BITS:0]                   shift_tmp;
	logic [mlt_pkg::WORD_BITS-1:0]                 shift_n;
	logic [mlt_pkg::RX_CNT_W-1:0]                  count_n;
	logic [mlt_pkg::WORD_BITS+mlt_pkg::BYTE_BITS-1:0] shift_pad;

	always_comb begin
		// early tick: late sample against this one; equal pairs decode nothing
		have_bit  = ~half_q & (late_q ^ rx_level);
		shift_tmp = {late_q, shift_q};
		shift_n   = have_bit ? shift_tmp[mlt_pkg::WORD_BITS:1] : shift_q;
		shift_pad = {{mlt_pkg::BYTE_BITS{1'b0}}, shift_n};
		rx_byte_valid = have_bit &&
			(count_q == mlt_pkg::RX_CNT_W'(mlt_pkg::WORD_BITS - 1));
		if (!have_bit)
			count_n = count_q;
		else if (rx_byte_valid)
			count_n = '0;
		else
			count_n = count_q + 1'b1;
		rx_byte = rx_byte_valid ? shift_pad[mlt_pkg::BYTE_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= 1'b0;
			late_q  <= 1'b0;
			shift_q <= '0;
			count_q <= '0;
		end else if (step) begin
			half_q  <= ~half_q;
			if (half_q)
				late_q <= rx_level;
			shift_q <= shift_n;
			count_q <= count_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mlt_out_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlt_out_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire mlt_pkg::mlt_result_t push_data,
	output logic                      push_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mlt_pkg::mlt_result_t      out_data
);

	logic                 main_valid_q;
	logic                 skid_valid_q;
	mlt_pkg::mlt_result_t main_q;
	mlt_pkg::mlt_result_t skid_q;
	logic                 pop;

	assign pop        = main_valid_q & out_ready;
	assign push_ready = ~skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (main_valid_q)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/manchester_line_transceiver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   -------------------------------------------
// tick in   in_valid / in_ready     rx_level, tx_load, tx_data[7:0]
// result    out_valid / out_ready   tx_line, tx_busy, rx_byte_valid, rx_byte[7:0]
//
// One request per clock while in_ready is high: each accepted tick updates the
// encoder and decoder state at once and its result is registered.
// The output register plus one skid entry let a tick be taken while the
// previous result is still waiting; in_ready drops only when both are full.
// Reset clears all line state: both coders start on a first half-bit, idle.
// Result stalls that fill both entries hold the state; nothing is dropped or repeated.

module manchester_line_transceiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          rx_level,
	input  wire logic                          tx_load,
	input  wire logic [mlt_pkg::BYTE_BITS-1:0] tx_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               tx_line,
	output logic                               tx_busy,
	output logic                               rx_byte_valid,
	output logic [mlt_pkg::BYTE_BITS-1:0]      rx_byte
);

	logic                          step;
	logic                          enc_line;
	logic                          enc_busy;
	logic                          dec_valid;
	logic [mlt_pkg::BYTE_BITS-1:0] dec_byte;
	mlt_pkg::mlt_result_t          result;
	mlt_pkg::mlt_result_t          out_data;

	// advance both coders on every accepted request
	assign step = in_valid & in_ready;

	// transmitter: LSB first, 1 as high-low, 0 as low-high, zeros when idle
	mlt_tx_enc u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.tx_load (tx_load),
		.tx_data (tx_data),
		.tx_line (enc_line),
		.tx_busy (enc_busy)
	);

	// receiver: pairs half-bits by tick parity since reset
	mlt_rx_dec u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_level      (rx_level),
		.rx_byte_valid (dec_valid),
		.rx_byte       (dec_byte)
	);

	// gather both halves into one result word
	assign result = {enc_line, enc_busy, dec_valid, dec_byte};

	// hold results until the consumer takes them
	mlt_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (result),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign tx_line       = out_data.tx_line;
	assign tx_busy       = out_data.tx_busy;
	assign rx_byte_valid = out_data.rx_byte_valid;
	assign rx_byte       = out_data.rx_byte;

endmodule

`default_nettype wire

// ===== hdl/mlt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mlt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          tx_line,
	input wire logic                          tx_busy,
	input wire logic                          rx_byte_valid,
	input wire logic [mlt_pkg::BYTE_BITS-1:0] rx_byte
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_line) && $stable(tx_busy)
			&& $stable(rx_byte_valid) && $stable(rx_byte))
		else $error("stalled result changed");

	// no byte shown without a completed word
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_byte_valid |-> rx_byte == '0)
		else $error("rx_byte set without rx_byte_valid");

	// back-pressure only with a result waiting
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with output empty");

	// a result appears only after a request
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without request");

	// ready drops only when a result was stalled
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without stall");

endmodule

bind manchester_line_transceiver mlt_checker u_mlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.tx_line       (tx_line),
	.tx_busy       (tx_busy),
	.rx_byte_valid (rx_byte_valid),
	.rx_byte       (rx_byte)
);

`default_nettype wire
